// ----- src/pbb_pkg.sv -----
package pbb_pkg;

  localparam int MAX_COLLIDERS = 4;
  localparam int PARTICLE_SIZE = 50;
  localparam logic [7:0] END_LEVEL = 8'd255;

  localparam int REG_COUNT = 1 + MAX_COLLIDERS;
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam int BOX_W = 36;
  localparam int IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_COLLIDER_COUNT = 3'd0;
  localparam logic [2:0] REG_COLLIDER_0 = 3'd1;
  localparam logic [2:0] REG_COLLIDER_3 = 3'd4;

  localparam logic FUNC_SPAWN = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic [2:0] count;
    logic [MAX_COLLIDERS-1:0][BOX_W-1:0] box;
  } pbb_cfg_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pbb_spawn_t;

  typedef struct packed {
    logic start;
    logic spawn;
    logic move;
    logic check;
    logic [IDX_W-1:0] idx;
    logic fade;
    logic emit;
  } pbb_cmd_t;

  typedef struct packed {
    logic live;
    logic hit;
    logic out_free;
  } pbb_status_t;

endpackage

// ----- src/pbb_item_if.sv -----
interface pbb_item_if;
  logic valid;
  logic ready;
  logic func;
  logic signed [15:0] spawn_x;
  logic signed [15:0] spawn_y;
  logic signed [15:0] spawn_vel_x;
  logic signed [15:0] spawn_vel_y;
  logic [7:0] spawn_red;
  logic [7:0] spawn_green;
  logic [7:0] spawn_blue;

  modport source (
    output valid, func, spawn_x, spawn_y, spawn_vel_x, spawn_vel_y,
           spawn_red, spawn_green, spawn_blue,
    input  ready
  );
  modport sink (
    input  valid, func, spawn_x, spawn_y, spawn_vel_x, spawn_vel_y,
           spawn_red, spawn_green, spawn_blue,
    output ready
  );
endinterface

// ----- src/pbb_result_if.sv -----
interface pbb_result_if;
  logic valid;
  logic ready;
  logic active;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic bounced_horizontal;
  logic bounced_vertical;

  modport source (
    output valid, active, pos_x, pos_y, red, green, blue,
           bounced_horizontal, bounced_vertical,
    input  ready
  );
  modport sink (
    input  valid, active, pos_x, pos_y, red, green, blue,
           bounced_horizontal, bounced_vertical,
    output ready
  );
endinterface

// ----- src/particle_box_bounce_step.sv -----
// One square particle that moves and bounces off up to four boxes. A spawn,
// or a tick on a particle never spawned, goes from its accepted transfer
// straight to the finish step; any other tick runs a move step, a check step
// per box examined, then finish. The boxes are examined one per cycle by a
// single compare unit until the first hit. The result register loads as the
// block returns to idle; a waiting result holds the block in finish until the
// output register is free. One item is in work at a time, and the next can
// be taken while the previous result still waits in the output register.
// Box i is at byte address 8*(i+1) of the configuration port, the count at 0.
module particle_box_bounce_step import pbb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  pbb_item_if.sink          item,
  pbb_result_if.source      result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  pbb_cfg_t    cfg;
  pbb_cmd_t    cmd;
  pbb_status_t status;
  pbb_spawn_t  spawn;

  assign spawn.x = item.spawn_x;
  assign spawn.y = item.spawn_y;
  assign spawn.vel_x = item.spawn_vel_x;
  assign spawn.vel_y = item.spawn_vel_y;
  assign spawn.red = item.spawn_red;
  assign spawn.green = item.spawn_green;
  assign spawn.blue = item.spawn_blue;

  pbb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pbb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_func  (item.func),
    .item_ready (item.ready),
    .count      (cfg.count),
    .status     (status),
    .cmd        (cmd)
  );

  pbb_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .spawn  (spawn),
    .cfg    (cfg),
    .status (status),
    .result (result)
  );

  // After a transfer in, the block is not ready in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("input taken on the cycle after an accepted item");

  // A particle that is not live never reports a bounce.
  a_bounce_needs_live: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.bounced_horizontal || result.bounced_vertical)
      |-> result.active)
    else $error("bounce reported for an inactive particle");

  // A new result is only loaded from the finish step, never while idle.
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(!item.ready))
    else $error("result loaded while the block was idle");

endmodule

// ----- src/pbb_regs.sv -----
module pbb_regs import pbb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output pbb_cfg_t          cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign index = paddr[5:3];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      if (index == REG_COLLIDER_COUNT) begin
        cfg.count <= pwdata[2:0];
      end else if (index >= REG_COLLIDER_0 && index <= REG_COLLIDER_3) begin
        cfg.box[IDX_W'(index - REG_COLLIDER_0)] <= pwdata[BOX_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (index == REG_COLLIDER_COUNT) begin
      prdata = {61'd0, cfg.count};
    end else if (index >= REG_COLLIDER_0 && index <= REG_COLLIDER_3) begin
      prdata = {28'd0, cfg.box[IDX_W'(index - REG_COLLIDER_0)]};
    end
  end

endmodule

// ----- src/pbb_ctrl.sv -----
module pbb_ctrl import pbb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_func,
  output logic        item_ready,
  input  logic [2:0]  count,
  input  pbb_status_t status,
  output pbb_cmd_t    cmd
);

  typedef enum logic [1:0] {
    IDLE,
    MOVE,
    CHECK,
    FINISH
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;
  logic             do_fade;
  logic [2:0]       n_boxes;
  logic             accept;
  logic             last_box;

  assign n_boxes = (count > 3'(MAX_COLLIDERS)) ? 3'(MAX_COLLIDERS) : count;
  assign accept = item_valid && item_ready;
  assign last_box = (3'(idx) + 3'd1) == n_boxes;
  assign item_ready = (state == IDLE);

  always_comb begin
    cmd = '0;
    cmd.idx = idx;
    case (state)
      IDLE: begin
        cmd.start = accept;
        cmd.spawn = accept && (item_func == FUNC_SPAWN);
      end
      MOVE: begin
        cmd.move = 1'b1;
      end
      CHECK: begin
        cmd.check = 1'b1;
      end
      FINISH: begin
        cmd.emit = status.out_free;
        cmd.fade = status.out_free && do_fade;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      idx <= '0;
      do_fade <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            idx <= '0;
            // A tick on a particle that was never spawned leaves everything alone.
            if (item_func == FUNC_TICK && status.live) begin
              do_fade <= 1'b1;
              state <= MOVE;
            end else begin
              do_fade <= 1'b0;
              state <= FINISH;
            end
          end
        end
        MOVE: begin
          state <= (n_boxes == 3'd0) ? FINISH : CHECK;
        end
        CHECK: begin
          if (status.hit || last_box) begin
            state <= FINISH;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        FINISH: begin
          if (status.out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/pbb_datapath.sv -----
module pbb_datapath import pbb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  pbb_cmd_t    cmd,
  input  pbb_spawn_t  spawn,
  input  pbb_cfg_t    cfg,
  output pbb_status_t status,
  pbb_result_if.source result
);

  localparam logic signed [19:0] SIZE_Q = 20'(PARTICLE_SIZE * 16);

  logic               live;
  logic signed [15:0] cur_x, cur_y, speed_x, speed_y;
  logic [7:0]         red, green, blue;
  logic               bh, bv;

  logic signed [16:0] sum_x, sum_y;
  logic signed [19:0] px, py, pxs, pys, bx, by, sd, bxe, bye;
  logic [BOX_W-1:0]   box;
  logic               in_x, in_y, hx, hy;
  logic [7:0]         red_nx, green_nx, blue_nx;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) return 16'sd32767;
    if (v < -17'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    return sat16(-{v[15], v});
  endfunction

  // Division by 40 of a value below 295: divide by 8, then by 5 through 13/64.
  function automatic logic [7:0] div40(input logic [8:0] d);
    logic [9:0] p;
    p = {4'd0, d[8:3]} * 10'd13;
    return {5'd0, p[8:6]};
  endfunction

  function automatic logic [7:0] fade(input logic [7:0] c);
    logic [8:0] d;
    if (c <= END_LEVEL) begin
      d = {1'b0, END_LEVEL - c};
      return c + div40(d);
    end
    d = {1'b0, c - END_LEVEL} + 9'd39;
    return c - div40(d);
  endfunction

  assign sum_x = 17'(cur_x) + 17'(speed_x);
  assign sum_y = 17'(cur_y) + 17'(speed_y);

  assign box = cfg.box[cmd.idx];
  assign px = 20'(cur_x);
  assign py = 20'(cur_y);
  assign pxs = px + SIZE_Q;
  assign pys = py + SIZE_Q;
  assign bx = $signed({4'd0, box[11:0], 4'd0});
  assign by = $signed({4'd0, box[23:12], 4'd0});
  assign sd = $signed({4'd0, box[35:24], 4'd0});
  assign bxe = bx + sd;
  assign bye = by + sd;

  assign in_y = (pys > by) && (py < bye);
  assign in_x = (pxs > bx) && (px < bxe);
  assign hx = in_y && ((speed_x > 16'sd0 && pxs > bx && px < bx) ||
                       (speed_x < 16'sd0 && px < bxe && pxs > bxe));
  assign hy = in_x && ((speed_y > 16'sd0 && pys > by && py < by) ||
                       (speed_y < 16'sd0 && py < bye && pys > bye));

  assign red_nx = cmd.fade ? fade(red) : red;
  assign green_nx = cmd.fade ? fade(green) : green;
  assign blue_nx = cmd.fade ? fade(blue) : blue;

  assign status.live = live;
  assign status.hit = cmd.check && (hx || hy);
  assign status.out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
      cur_x <= '0;
      cur_y <= '0;
      speed_x <= '0;
      speed_y <= '0;
      red <= '0;
      green <= '0;
      blue <= '0;
      result.valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        bh <= 1'b0;
        bv <= 1'b0;
      end
      if (cmd.spawn) begin
        live <= 1'b1;
        cur_x <= spawn.x;
        cur_y <= spawn.y;
        speed_x <= spawn.vel_x;
        speed_y <= spawn.vel_y;
        red <= spawn.red;
        green <= spawn.green;
        blue <= spawn.blue;
      end
      if (cmd.move) begin
        cur_x <= sat16(sum_x);
        cur_y <= sat16(sum_y);
      end
      if (cmd.check && hx) begin
        speed_x <= neg_sat(speed_x);
        bh <= 1'b1;
      end
      if (cmd.check && hy) begin
        speed_y <= neg_sat(speed_y);
        bv <= 1'b1;
      end
      if (cmd.fade) begin
        red <= red_nx;
        green <= green_nx;
        blue <= blue_nx;
      end
      if (cmd.emit) begin
        result.valid <= 1'b1;
        result.active <= live;
        result.pos_x <= cur_x;
        result.pos_y <= cur_y;
        result.red <= red_nx;
        result.green <= green_nx;
        result.blue <= blue_nx;
        result.bounced_horizontal <= bh;
        result.bounced_vertical <= bv;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import pbb_pkg::*;

  localparam int SPAN = PARTICLE_SIZE * 16;
  localparam int FIRST_BOX_ROW = 7;
  localparam int ROW_COUNT = 18;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int SETTLE_CYCLES = 10;
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic func;
    pbb_spawn_t sp;
  } particle_cmd_t;

  typedef struct packed {
    logic active;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic bounced_horizontal;
    logic bounced_vertical;
  } particle_view_t;

  typedef struct {
    particle_cmd_t cmd;
    bit typed;
    particle_view_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  pbb_item_if item_bus ();
  pbb_result_if result_bus ();

  particle_box_bounce_step dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Shadow copy of the particle and of the box registers.
  bit pm_live = 1'b0;
  logic signed [15:0] pm_x = '0;
  logic signed [15:0] pm_y = '0;
  logic signed [15:0] pm_vx = '0;
  logic signed [15:0] pm_vy = '0;
  logic [7:0] pm_red = '0;
  logic [7:0] pm_green = '0;
  logic [7:0] pm_blue = '0;
  logic [2:0] box_count = '0;
  logic [BOX_W-1:0] boxes [MAX_COLLIDERS] = '{default: '0};

  particle_view_t due_results [$];
  int mismatches = 0;
  int results_seen = 0;
  int hold = 0;
  bit calm = 1'b0;
  stim_row_t demo_rows [ROW_COUNT];

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic [7:0] fade_channel(logic [7:0] c);
    int e;
    int ci;
    e = END_LEVEL;
    ci = c;
    if (ci <= e) return 8'(ci + (e - ci) / 40);
    return 8'(ci - ((ci - e) + 39) / 40);
  endfunction

  function automatic particle_cmd_t mk_cmd(logic f, int x, int y, int vx, int vy,
                                           int r, int g, int b);
    particle_cmd_t c;
    c.func = f;
    c.sp.x = x[15:0];
    c.sp.y = y[15:0];
    c.sp.vel_x = vx[15:0];
    c.sp.vel_y = vy[15:0];
    c.sp.red = r[7:0];
    c.sp.green = g[7:0];
    c.sp.blue = b[7:0];
    return c;
  endfunction

  function automatic particle_view_t mk_view(logic act, int x, int y, int r, int g, int b,
                                             logic bh, logic bv);
    particle_view_t v;
    v.active = act;
    v.pos_x = x[15:0];
    v.pos_y = y[15:0];
    v.red = r[7:0];
    v.green = g[7:0];
    v.blue = b[7:0];
    v.bounced_horizontal = bh;
    v.bounced_vertical = bv;
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] box_word(int x, int y, int side);
    return {28'd0, side[11:0], y[11:0], x[11:0]};
  endfunction

  // Applies one item to the shadow particle and returns the view it produces.
  function automatic particle_view_t advance_particle(particle_cmd_t c);
    particle_view_t v;
    int n;
    int px;
    int py;
    int vx;
    int vy;
    int bx;
    int by;
    int sd;
    bit bh;
    bit bv;
    bit hit;
    bit in_x;
    bit in_y;
    bh = 1'b0;
    bv = 1'b0;
    if (c.func == FUNC_SPAWN) begin
      pm_x = c.sp.x;
      pm_y = c.sp.y;
      pm_vx = c.sp.vel_x;
      pm_vy = c.sp.vel_y;
      pm_red = c.sp.red;
      pm_green = c.sp.green;
      pm_blue = c.sp.blue;
      pm_live = 1'b1;
    end else if (pm_live) begin
      n = (box_count > MAX_COLLIDERS) ? MAX_COLLIDERS : box_count;
      pm_x = clamp16(int'(pm_x) + int'(pm_vx));
      pm_y = clamp16(int'(pm_y) + int'(pm_vy));
      px = pm_x;
      py = pm_y;
      vx = pm_vx;
      vy = pm_vy;
      for (int i = 0; i < n; i++) begin
        bx = 16 * boxes[i][11:0];
        by = 16 * boxes[i][23:12];
        sd = 16 * boxes[i][35:24];
        hit = 1'b0;
        in_y = (py + SPAN > by) && (py < by + sd);
        in_x = (px + SPAN > bx) && (px < bx + sd);
        if ((vx > 0 && px + SPAN > bx && px < bx && in_y) ||
            (vx < 0 && px < bx + sd && px + SPAN > bx + sd && in_y)) begin
          vx = clamp16(-vx);
          bh = 1'b1;
          hit = 1'b1;
        end
        if ((vy > 0 && py + SPAN > by && py < by && in_x) ||
            (vy < 0 && py < by + sd && py + SPAN > by + sd && in_x)) begin
          vy = clamp16(-vy);
          bv = 1'b1;
          hit = 1'b1;
        end
        if (hit) break;
      end
      pm_vx = vx[15:0];
      pm_vy = vy[15:0];
      pm_red = fade_channel(pm_red);
      pm_green = fade_channel(pm_green);
      pm_blue = fade_channel(pm_blue);
    end
    v.active = pm_live;
    v.pos_x = pm_x;
    v.pos_y = pm_y;
    v.red = pm_red;
    v.green = pm_green;
    v.blue = pm_blue;
    v.bounced_horizontal = bh;
    v.bounced_vertical = bv;
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("ERROR %0t: %s", $time, msg);
  endtask

  // Called at a rising edge; returns once the write has taken place.
  task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 3'b000});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_COLLIDER_COUNT) box_count = value[2:0];
    else boxes[2'(idx - REG_COLLIDER_0)] = value[BOX_W-1:0];
    @(posedge clk);
  endtask

  task automatic send_cmd(particle_cmd_t c, bit typed, particle_view_t want);
    particle_view_t predicted;
    if (!calm && $urandom_range(0, 2) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.func <= c.func;
    item_bus.spawn_x <= c.sp.x;
    item_bus.spawn_y <= c.sp.y;
    item_bus.spawn_vel_x <= c.sp.vel_x;
    item_bus.spawn_vel_y <= c.sp.vel_y;
    item_bus.spawn_red <= c.sp.red;
    item_bus.spawn_green <= c.sp.green;
    item_bus.spawn_blue <= c.sp.blue;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    predicted = advance_particle(c);
    due_results.push_back(typed ? want : predicted);
  endtask

  // Waits until every result is back so that the registers can be touched.
  task automatic drain();
    item_bus.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_view();
    particle_view_t got;
    particle_view_t want;
    string bad;
    got.active = result_bus.active;
    got.pos_x = result_bus.pos_x;
    got.pos_y = result_bus.pos_y;
    got.red = result_bus.red;
    got.green = result_bus.green;
    got.blue = result_bus.blue;
    got.bounced_horizontal = result_bus.bounced_horizontal;
    got.bounced_vertical = result_bus.bounced_vertical;
    results_seen++;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing outstanding", results_seen));
      return;
    end
    want = due_results.pop_front();
    bad = "";
    if (got.active !== want.active) bad = {bad, " active"};
    if (got.pos_x !== want.pos_x) bad = {bad, " pos_x"};
    if (got.pos_y !== want.pos_y) bad = {bad, " pos_y"};
    if (got.red !== want.red) bad = {bad, " red"};
    if (got.green !== want.green) bad = {bad, " green"};
    if (got.blue !== want.blue) bad = {bad, " blue"};
    if (got.bounced_horizontal !== want.bounced_horizontal) bad = {bad, " bounced_horizontal"};
    if (got.bounced_vertical !== want.bounced_vertical) bad = {bad, " bounced_vertical"};
    if (bad != "")
      report_mismatch($sformatf("result %0d wrong in%s: got %p want %p",
                                results_seen, bad, got, want));
  endtask

  // Result side: check each transfer, then decide whether to stall next cycle.
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) check_view();
    if (hold > 0) hold--;
    else if (!calm && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 4);
    result_bus.ready <= (hold == 0);
  end

  initial begin
    #2_000_000;
    $display("particle_box_bounce_step regression: fail");
    $finish;
  end

  initial begin
    particle_cmd_t c;
    int n;
    int ticks;
    int kind;
    int cnt;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_bus.valid = 1'b0;
    item_bus.func = FUNC_SPAWN;
    item_bus.spawn_x = '0;
    item_bus.spawn_y = '0;
    item_bus.spawn_vel_x = '0;
    item_bus.spawn_vel_y = '0;
    item_bus.spawn_red = '0;
    item_bus.spawn_green = '0;
    item_bus.spawn_blue = '0;
    result_bus.ready = 1'b0;

    // Tick before any spawn, then saturation at both ends of the range.
    demo_rows[0] = '{mk_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                     mk_view(0, 0, 0, 0, 0, 0, 0, 0)};
    demo_rows[1] = '{mk_cmd(FUNC_SPAWN, 32767, -32768, 32767, -32768, 0, 255, 128), 1'b1,
                     mk_view(1, 32767, -32768, 0, 255, 128, 0, 0)};
    demo_rows[2] = '{mk_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                     mk_view(1, 32767, -32768, 6, 255, 131, 0, 0)};
    demo_rows[3] = '{mk_cmd(FUNC_SPAWN, -32768, 32767, -32768, 32767, 255, 0, 1), 1'b1,
                     mk_view(1, -32768, 32767, 255, 0, 1, 0, 0)};
    demo_rows[4] = '{mk_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                     mk_view(1, -32768, 32767, 255, 6, 7, 0, 0)};
    demo_rows[5] = '{mk_cmd(FUNC_SPAWN, 0, 0, 0, 0, 216, 215, 40), 1'b1,
                     mk_view(1, 0, 0, 216, 215, 40, 0, 0)};
    demo_rows[6] = '{mk_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    // From here on the boxes are loaded. Negating the most negative speed:
    demo_rows[7] = '{mk_cmd(FUNC_SPAWN, 32767, 0, -32768, 0, 200, 100, 50), 1'b1,
                     mk_view(1, 32767, 0, 200, 100, 50, 0, 0)};
    demo_rows[8] = '{mk_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    demo_rows[9] = '{mk_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    // Vertical bounce off the top edge of the second box.
    demo_rows[10] = '{mk_cmd(FUNC_SPAWN, 1600, 800, 0, 16, 10, 20, 30), 1'b0, '0};
    demo_rows[11] = '{mk_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    demo_rows[12] = '{mk_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    // Both bounces from one box, with a spawn over a live particle.
    demo_rows[13] = '{mk_cmd(FUNC_SPAWN, 800, 800, 16, 16, 254, 1, 128), 1'b0, '0};
    demo_rows[14] = '{mk_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    // Touching an edge exactly is not a crossing; one step further is.
    demo_rows[15] = '{mk_cmd(FUNC_SPAWN, 784, 1000, 16, 0, 77, 88, 99), 1'b0, '0};
    demo_rows[16] = '{mk_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    demo_rows[17] = '{mk_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < ROW_COUNT; i++) begin
      if (i == FIRST_BOX_ROW) begin
        drain();
        // A count above the limit falls back to all four boxes.
        write_reg(REG_COLLIDER_COUNT, 64'd7);
        write_reg(REG_COLLIDER_0, box_word(0, 0, 1));
        write_reg(REG_COLLIDER_0 + 3'd1, box_word(100, 100, 20));
        write_reg(REG_COLLIDER_0 + 3'd2, 64'hf_ffff_ffff);
        write_reg(REG_COLLIDER_3, 64'd0);
      end
      send_cmd(demo_rows[i].cmd, demo_rows[i].typed, demo_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      calm = (ph == PHASES - 1);
      cnt = (ph == 0) ? MAX_COLLIDERS : $urandom_range(0, 7);
      write_reg(REG_COLLIDER_COUNT, 64'(cnt));
      for (int b = 0; b < MAX_COLLIDERS; b++) begin
        if (ph == 2)
          write_reg(REG_COLLIDER_0 + 3'(b), {$urandom, $urandom} & 64'hf_ffff_ffff);
        else
          write_reg(REG_COLLIDER_0 + 3'(b), box_word($urandom_range(0, 200),
                    $urandom_range(0, 200), $urandom_range(1, 120)));
      end
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          send_cmd(mk_cmd(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom), 1'b0, '0);
          n++;
        end else begin
          // Mostly a particle launched near the boxes, now and then arbitrary bits.
          if (kind == 1)
            c = mk_cmd(FUNC_SPAWN, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
          else
            c = mk_cmd(FUNC_SPAWN, int'($urandom_range(0, 4800)) - 800,
                       int'($urandom_range(0, 4800)) - 800,
                       int'($urandom_range(0, 128)) - 64, int'($urandom_range(0, 128)) - 64,
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255));
          send_cmd(c, 1'b0, '0);
          n++;
          ticks = $urandom_range(1, 30);
          if (ticks > ITEMS_PER_PHASE - n) ticks = ITEMS_PER_PHASE - n;
          repeat (ticks) begin
            send_cmd(mk_cmd(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom), 1'b0, '0);
            n++;
          end
        end
      end
    end

    drain();
    if (mismatches == 0) $display("particle_box_bounce_step regression: pass");
    else $display("particle_box_bounce_step regression: fail");
    $finish;
  end

endmodule
